// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the timing wheel RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define HTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Types and constants of the hashed timing wheel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package htw_pkg;

  localparam int WHEEL_SLOTS = 256;
  localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
  localparam int TIMER_COUNT = 16;
  localparam int ID_W        = 4;
  localparam int TICKS_W     = 32;
  localparam int ROUNDS_W    = TICKS_W - SLOT_W;
  localparam int DIV_W       = 16;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIVIDE,
    S_SCAN,
    S_EMPTY
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                 eval;
    logic                 place;
    logic                 stop;
    logic                 clr;
    logic                 adv;
    logic [TICKS_W-1:0]   ticks;
    logic                 periodic;
    logic [SLOT_W-1:0]    cur_slot;
  } cell_cmd_t;

endpackage

// File: rtl/htw_in_if.sv
// ----------------------------------------------------------------------------
// htw_in_if
// Input item channel: action, timer number, interval, periodic flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface htw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  timer_id;
  logic [31:0] interval;
  logic        periodic;

  modport source (output valid, action, timer_id, interval, periodic, input ready);
  modport sink   (input valid, action, timer_id, interval, periodic, output ready);
endinterface

// File: rtl/htw_out_if.sv
// ----------------------------------------------------------------------------
// htw_out_if
// Result item channel: fired flag, expired timer number, last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface htw_out_if;
  logic       valid;
  logic       ready;
  logic       fired;
  logic [3:0] expired_id;
  logic       last;

  modport source (output valid, fired, expired_id, last, input ready);
  modport sink   (input valid, fired, expired_id, last, output ready);
endinterface

// File: rtl/htw_cfg_if.sv
// ----------------------------------------------------------------------------
// htw_cfg_if
// Configuration write channel carrying the tick length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface htw_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/htw_divider.sv
// ----------------------------------------------------------------------------
// htw_divider
// Restoring divider, one quotient bit per cycle while busy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htw_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [htw_pkg::TICKS_W-1:0]   dividend,
  input  logic [htw_pkg::DIV_W-1:0]     divisor,
  output logic                          done,
  output logic [htw_pkg::TICKS_W-1:0]   quotient
);

  localparam int CNT_W = $clog2(htw_pkg::TICKS_W);

  logic                          busy;
  logic [CNT_W-1:0]              cnt;
  logic [htw_pkg::DIV_W-1:0]     dvs;
  logic [htw_pkg::DIV_W-1:0]     rem;
  logic [htw_pkg::DIV_W:0]       trial;
  logic                          qbit;

  // Shift in the next dividend bit and try the subtract
  assign trial = {rem, quotient[htw_pkg::TICKS_W-1]};
  assign qbit  = (trial >= {1'b0, dvs});

  // Control: count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(htw_pkg::TICKS_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: a zero divisor divides like one
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= (divisor == '0) ? htw_pkg::DIV_W'(1) : divisor;
    end else if (busy) begin
      rem      <= qbit ? htw_pkg::DIV_W'(trial - {1'b0, dvs})
                       : trial[htw_pkg::DIV_W-1:0];
      quotient <= {quotient[htw_pkg::TICKS_W-2:0], qbit};
    end
  end

endmodule

// File: rtl/htw_cell.sv
// ----------------------------------------------------------------------------
// htw_cell
// One timer entry of the chain: slot, rounds, reload, pending fire, token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htw_cell (
  input  logic               clk,
  input  logic               rst,
  input  htw_pkg::cell_cmd_t cmd,
  input  logic               sel,
  input  logic               token_in,
  output logic               token_out,
  output logic               pend
);

  logic                           active;
  logic                           periodic;
  logic [htw_pkg::SLOT_W-1:0]     slot;
  logic [htw_pkg::ROUNDS_W-1:0]   rounds;
  logic [htw_pkg::TICKS_W-1:0]    reload;
  logic                           visit;

  assign visit = active && (slot == cmd.cur_slot);

  // Control bits: active, pending fire, scan token
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      pend      <= 1'b0;
      token_out <= 1'b0;
    end else begin
      if (cmd.adv) begin
        token_out <= token_in;
      end
      if (cmd.eval) begin
        if (visit && rounds == '0) begin
          pend <= 1'b1;
          if (!periodic) begin
            active <= 1'b0;
          end
        end
      end else if (cmd.place && sel) begin
        active <= 1'b1;
      end else if (cmd.stop && sel) begin
        active <= 1'b0;
      end
      if (cmd.clr && token_out) begin
        pend <= 1'b0;
      end
    end
  end

  // Timer payload: place, count down, reload
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (visit) begin
        if (rounds != '0) begin
          rounds <= rounds - 1'b1;
        end else if (periodic) begin
          slot   <= cmd.cur_slot + reload[htw_pkg::SLOT_W-1:0];
          rounds <= reload[htw_pkg::TICKS_W-1:htw_pkg::SLOT_W];
        end
      end
    end else if (cmd.place && sel) begin
      reload   <= cmd.ticks;
      periodic <= cmd.periodic;
      slot     <= cmd.cur_slot + cmd.ticks[htw_pkg::SLOT_W-1:0];
      rounds   <= cmd.ticks[htw_pkg::TICKS_W-1:htw_pkg::SLOT_W];
    end
  end

endmodule

// File: rtl/hashed_timing_wheel_unit.sv
// ----------------------------------------------------------------------------
// hashed_timing_wheel_unit
// Hashed timing wheel over a chain of sixteen timer cells.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  accepted when
//  req      in   action, timer_id, interval, periodic     valid && ready
//  rsp      out  fired, expired_id, last                  valid && ready
//  cfg      in   data (tick length)                       valid && ready
//
//  Start: the serial divider forms the tick count, then the timer is placed.
//  Tick: all cells evaluate, then a token walks the cell chain one cell a
//  cycle, except while a stalled result holds it in place.
//  Stop and ignored items: straight on to the empty result.
//  Reset (rst, synchronous) frees all timers and sets the slot to 0.
//  A stalled result holds the token in place; the result register frees
//  the input side once its item is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hashed_timing_wheel_unit (
  input  logic       clk,
  input  logic       rst,
  htw_in_if.sink     req,
  htw_out_if.source  rsp,
  htw_cfg_if.sink    cfg
);

  localparam int N = htw_pkg::TIMER_COUNT;

  htw_pkg::state_t                state, state_next;
  htw_pkg::cell_cmd_t             cmd;
  logic [htw_pkg::DIV_W-1:0]      tick_length;
  logic [htw_pkg::SLOT_W-1:0]     cur_slot;
  logic [htw_pkg::ID_W-1:0]       id_q;
  logic                           per_q;
  logic                           accept, id_ok, div_start, div_done;
  logic [htw_pkg::TICKS_W-1:0]    quotient;
  logic [N-1:0]                   sel, pend, tokens;
  logic [N:0]                     chain;
  logic                           here, last_f, out_free;
  logic                           emit, emit_fired, emit_last;
  logic [htw_pkg::ID_W-1:0]       tok_id;
  logic                           o_valid, o_fired, o_last;
  logic [htw_pkg::ID_W-1:0]       o_id;

  assign accept   = req.valid && req.ready;
  assign id_ok    = (32'(req.timer_id) < N);
  assign out_free = !o_valid || rsp.ready;
  assign here     = |(tokens & pend);
  assign last_f   = ((pend & ~tokens) == '0);

  // Configuration register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_length <= htw_pkg::DIV_W'(1);
    end else if (cfg.valid) begin
      tick_length <= cfg.data;
    end
  end

  // Encode the token position
  always_comb begin
    tok_id = '0;
    for (int i = 0; i < N; i++) begin
      if (tokens[i]) tok_id = htw_pkg::ID_W'(i);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      htw_pkg::S_IDLE: begin
        if (accept) begin
          if (req.action == htw_pkg::ACT_START && id_ok) state_next = htw_pkg::S_DIVIDE;
          else if (req.action == htw_pkg::ACT_TICK)      state_next = htw_pkg::S_SCAN;
          else                                           state_next = htw_pkg::S_EMPTY;
        end
      end
      htw_pkg::S_DIVIDE: if (div_done) state_next = htw_pkg::S_EMPTY;
      htw_pkg::S_SCAN: begin
        if (pend == '0)                       state_next = htw_pkg::S_EMPTY;
        else if (here && out_free && last_f)  state_next = htw_pkg::S_IDLE;
      end
      htw_pkg::S_EMPTY: if (out_free) state_next = htw_pkg::S_IDLE;
      default: state_next = htw_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    req.ready    = (state == htw_pkg::S_IDLE);
    div_start    = 1'b0;
    emit         = 1'b0;
    emit_fired   = 1'b0;
    emit_last    = 1'b1;
    cmd.eval     = 1'b0;
    cmd.place    = 1'b0;
    cmd.stop     = 1'b0;
    cmd.clr      = 1'b0;
    cmd.adv      = 1'b0;
    cmd.ticks    = quotient;
    cmd.periodic = per_q;
    cmd.cur_slot = cur_slot;
    chain[0]     = 1'b0;
    unique case (state)
      htw_pkg::S_IDLE: begin
        if (accept) begin
          div_start = (req.action == htw_pkg::ACT_START) && id_ok;
          cmd.stop  = (req.action == htw_pkg::ACT_STOP) && id_ok;
          if (req.action == htw_pkg::ACT_TICK) begin
            cmd.eval = 1'b1;
            cmd.adv  = 1'b1;
            chain[0] = 1'b1;
          end
        end
      end
      htw_pkg::S_DIVIDE: cmd.place = div_done;
      htw_pkg::S_SCAN: begin
        cmd.adv = !(here && !out_free);
        if (here && out_free) begin
          emit       = 1'b1;
          emit_fired = 1'b1;
          emit_last  = last_f;
          cmd.clr    = 1'b1;
        end
      end
      htw_pkg::S_EMPTY: emit = out_free;
      default: ;
    endcase
  end

  // Select the addressed cell
  always_comb begin
    for (int i = 0; i < N; i++) begin
      sel[i] = (state == htw_pkg::S_DIVIDE) ? (id_q == htw_pkg::ID_W'(i))
                                            : (req.timer_id == htw_pkg::ID_W'(i));
    end
  end

  // State, slot pointer and start latch
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= htw_pkg::S_IDLE;
      cur_slot <= '0;
    end else begin
      state <= state_next;
      if (cmd.eval) cur_slot <= cur_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      id_q  <= req.timer_id;
      per_q <= req.periodic;
    end
  end

  htw_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.interval),
    .divisor  (tick_length),
    .done     (div_done),
    .quotient (quotient)
  );

  // Chain of timer cells; the token hands from each cell to the next.
  // A new tick drops any token left in the chain by the previous scan.
  for (genvar g = 0; g < N; g++) begin : g_cell
    htw_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .sel       (sel[g]),
      .token_in  ((g == 0) ? chain[0] : (chain[g] && !cmd.eval)),
      .token_out (chain[g+1]),
      .pend      (pend[g])
    );
    assign tokens[g] = chain[g+1];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_fired <= emit_fired;
      o_id    <= emit_fired ? tok_id : '0;
      o_last  <= emit_last;
    end
  end

  assign rsp.valid      = o_valid;
  assign rsp.fired      = o_fired;
  assign rsp.expired_id = o_id;
  assign rsp.last       = o_last;

  `HTW_ASSERT_NOW(a_token_onehot, 1'b1, $onehot0(tokens))
  `HTW_ASSERT_NOW(a_div_in_divide, div_done, state == htw_pkg::S_DIVIDE)
  `HTW_ASSERT_NEXT(a_last_clears, emit && emit_fired && emit_last, pend == '0)

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives start, stop, tick and ignored items into the timing wheel under random idling,
// predicts the expiry results and compares every result item field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  timer_id;
    logic [31:0] interval;
    logic        periodic;
  } cmd_item_t;

  typedef struct packed {
    logic       fired;
    logic [3:0] expired_id;
    logic       last;
  } expiry_t;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  htw_in_if  req ();
  htw_out_if rsp ();
  htw_cfg_if cfg ();

  hashed_timing_wheel_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  always #5 clk = ~clk;

  // Wheel state mirror
  logic [15:0] div_len;
  logic [7:0]  cur_slot;
  logic        t_active [16];
  logic [7:0]  t_slot [16];
  logic [23:0] t_rounds [16];
  logic [31:0] t_reload [16];
  logic        t_per [16];

  cmd_item_t pending_cmds[$];
  expiry_t   expiry_q[$];
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  bit        drain_done = 1'b0;
  bit        in_taken = 1'b0;
  int        in_gap = 0;
  int        out_gap = 0;

  task automatic place_timer(input int t, input logic [31:0] ticks);
    logic [31:0] rnd;
    rnd = ticks / htw_pkg::WHEEL_SLOTS;
    t_rounds[t] = (rnd > 32'hFFFFFF) ? 24'hFFFFFF : rnd[23:0];
    t_slot[t]   = cur_slot + ticks[7:0];
    t_active[t] = 1'b1;
  endtask

  // Compute the results of one accepted item
  task automatic predict_expiry(input cmd_item_t c);
    logic visit [16];
    logic [31:0] dv;
    logic [31:0] ticks;
    int n;
    n = 0;
    case (c.action)
      htw_pkg::ACT_START: begin
        dv = (div_len == 0) ? 32'd1 : {16'd0, div_len};
        ticks = c.interval / dv;
        t_reload[c.timer_id] = ticks;
        t_per[c.timer_id] = c.periodic;
        place_timer(c.timer_id, ticks);
      end
      htw_pkg::ACT_STOP: t_active[c.timer_id] = 1'b0;
      htw_pkg::ACT_TICK: begin
        for (int t = 0; t < 16; t++) visit[t] = t_active[t] && t_slot[t] == cur_slot;
        for (int t = 0; t < 16; t++) begin
          if (visit[t]) begin
            if (t_rounds[t] > 0) begin
              t_rounds[t]--;
            end else begin
              expiry_q.push_back('{1'b1, 4'(t), 1'b0});
              n++;
              if (t_per[t]) place_timer(t, t_reload[t]);
              else t_active[t] = 1'b0;
            end
          end
        end
        cur_slot = cur_slot + 8'd1;
      end
      default: ;
    endcase
    if (n == 0) expiry_q.push_back('{1'b0, 4'd0, 1'b1});
    else expiry_q[$].last = 1'b1;
  endtask

  // Driver: present pending items with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      in_taken <= 1'b0;
      if (req.valid && !in_taken) begin
        // hold the current item
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        req.valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
        in_gap <= $urandom_range(1, 12) - 1;
        req.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        req.valid    <= 1'b1;
        req.action   <= pending_cmds[0].action;
        req.timer_id <= pending_cmds[0].timer_id;
        req.interval <= pending_cmds[0].interval;
        req.periodic <= pending_cmds[0].periodic;
      end else begin
        req.valid <= 1'b0;
      end
      // result side back-pressure
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        rsp.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(1, 12) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on acceptance, check each result
  always @(posedge clk) begin
    expiry_t got, want;
    cycles <= cycles + 1;
    if (!rst) begin
      if (req.valid && req.ready) begin
        void'(pending_cmds.pop_front());
        in_taken <= 1'b1;
        predict_expiry('{req.action, req.timer_id, req.interval, req.periodic});
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.fired, rsp.expired_id, rsp.last};
        if (expiry_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result %b %0d %b", got.fired,
                                    got.expired_id, got.last);
        end else begin
          want = expiry_q.pop_front();
          if (got !== want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: exp fired=%b id=%0d last=%b got fired=%b id=%0d last=%b",
                       want.fired, want.expired_id, want.last,
                       got.fired, got.expired_id, got.last);
          end
        end
      end
    end
  end

  task automatic push_cmd(input logic [1:0] a, input logic [3:0] id,
                          input logic [31:0] iv, input logic p);
    pending_cmds.push_back('{a, id, iv, p});
  endtask

  // Wait until every queued item is taken and every result has come
  task automatic wait_quiet();
    while (pending_cmds.size() > 0 || req.valid || expiry_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_tick_len(input logic [15:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    div_len = v;
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Mostly start/tick traffic with mostly short intervals so expiries happen
  task automatic random_block(input int count, input int span);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30)
        push_cmd(htw_pkg::ACT_START, 4'($urandom_range(0, 15)),
                 ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, span),
                 1'($urandom_range(0, 1)));
      else if (r < 38)
        push_cmd(htw_pkg::ACT_STOP, 4'($urandom_range(0, 15)), $urandom(),
                 1'($urandom_range(0, 1)));
      else if (r < 41)
        push_cmd(htw_pkg::ACT_NONE, 4'($urandom_range(0, 15)), $urandom(),
                 1'($urandom_range(0, 1)));
      else
        push_cmd(htw_pkg::ACT_TICK, 4'($urandom_range(0, 15)), $urandom(),
                 1'($urandom_range(0, 1)));
    end
  endtask

  // Timeout
  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0; req.action = htw_pkg::ACT_NONE; req.timer_id = '0;
    req.interval = '0; req.periodic = 1'b0;
    rsp.ready = 1'b0; cfg.valid = 1'b0; cfg.data = '0;
    div_len = 16'd1; cur_slot = '0;
    for (int t = 0; t < 16; t++) begin
      t_active[t] = 1'b0; t_slot[t] = '0; t_rounds[t] = '0; t_reload[t] = '0; t_per[t] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero interval, extremes, restart, idle stop, unknown action
    push_cmd(htw_pkg::ACT_START, 4'd0, 32'd0, 1'b0);
    push_cmd(htw_pkg::ACT_START, 4'd15, 32'd0, 1'b1);
    push_cmd(htw_pkg::ACT_START, 4'd5, 32'd1, 1'b0);
    push_cmd(htw_pkg::ACT_START, 4'd5, 32'd2, 1'b1);
    push_cmd(htw_pkg::ACT_START, 4'd7, 32'hFFFFFFFF, 1'b1);
    push_cmd(htw_pkg::ACT_STOP, 4'd9, 32'hFFFFFFFF, 1'b1);
    push_cmd(htw_pkg::ACT_NONE, 4'd15, 32'hFFFFFFFF, 1'b1);
    push_cmd(htw_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0);
    push_cmd(htw_pkg::ACT_START, 4'd3, 32'd256, 1'b1);
    push_cmd(htw_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0);
    push_cmd(htw_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0);
    push_cmd(htw_pkg::ACT_STOP, 4'd15, 32'd0, 1'b0);
    push_cmd(htw_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0);
    wait_quiet();

    write_tick_len(16'd0);
    push_cmd(htw_pkg::ACT_START, 4'd1, 32'd3, 1'b0);
    push_cmd(htw_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0);
    wait_quiet();
    write_tick_len(16'hFFFF);
    push_cmd(htw_pkg::ACT_START, 4'd2, 32'hFFFFFFFF, 1'b0);
    push_cmd(htw_pkg::ACT_START, 4'd4, 32'd65534, 1'b0);
    push_cmd(htw_pkg::ACT_TICK, 4'd0, 32'd0, 1'b0);
    wait_quiet();

    // Random phases over several tick lengths
    write_tick_len(16'd1);
    random_block(50, 600);
    wait_quiet();
    write_tick_len(16'd3);
    random_block(50, 900);
    wait_quiet();
    write_tick_len(16'd1);
    calm = 1'b1;
    random_block(50, 40);
    wait_quiet();
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/htw_pkg.sv
rtl/htw_in_if.sv
rtl/htw_out_if.sv
rtl/htw_cfg_if.sv
rtl/htw_divider.sv
rtl/htw_cell.sv
rtl/hashed_timing_wheel_unit.sv
sim/testbench.sv
